// ----- rtl/core/dpa_pkg.sv -----
`timescale 1ns / 1ps
package dpa_pkg;

  // angle resolution before rescaling to 16 bits
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 30;
  localparam int MAG_W        = 30;
  localparam int DIV_STEPS    = 33;
  localparam int SQRT_STEPS   = 18;
  localparam int FIFO_DEPTH   = 4;

  // back end latencies in stages
  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int ASYM_LAT   = 2 + DIV_STEPS + SQRT_STEPS;
  localparam int PHASE_DLY  = ASYM_LAT - CORDIC_LAT;

  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SAMPLE_X   = 2'd0,
    REG_SAMPLE_Y   = 2'd1,
    REG_SAMPLE_Z   = 2'd2,
    REG_FIELD_AXIS = 2'd3
  } cfg_reg_t;

  // field axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // classified item handed from front to back
  typedef struct packed {
    logic [15:0]      index;
    logic             num_neg;
    logic             den_neg;
    logic [MAG_W-1:0] mag_n;
    logic [MAG_W-1:0] mag_d;
    logic [MAG_W-1:0] mag_o;
    logic             zero;
  } dpa_item_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933405;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335086;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41721;
      15: v = 32'd20860;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2607;
      19: v = 32'd1303;
      20: v = 32'd651;
      21: v = 32'd325;
      22: v = 32'd162;
      23: v = 32'd81;
      24: v = 32'd40;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd2;
      29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/detector_phase_asymmetry.sv -----
`timescale 1ns / 1ps
// channel  | direction | handshake           | payload
// in_      | in        | in_valid, in_stall   | det_index, det_x, det_y, det_z
// out_     | out       | out_valid, out_stall | index, phase, asymmetry, zero_radius
// cfg_     | in        | cfg_we               | cfg_addr, cfg_wdata
//
// one item per cycle sustained while out_stall is low; the path holds 3 front
// stages, the queue and 53 back stages, set by the 33-step divider and 18-step
// square root (the 32-stage cordic runs beside them and is delayed to match)
// rst_n is synchronous; it clears the configuration, queue and valid bits
// a stalled output freezes the whole back pipeline; the 4-entry queue lets
// the front keep accepting until it fills

module detector_phase_asymmetry
  import dpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_det_index,
  input  logic [31:0] in_det_x,
  input  logic [31:0] in_det_y,
  input  logic [31:0] in_det_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_index,
  output logic [15:0] out_phase,
  output logic [16:0] out_asymmetry,
  output logic        out_zero_radius,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] sample_x_r, sample_y_r, sample_z_r;
  logic [1:0]  field_axis_r;

  logic        q_push, q_pop, q_full, q_empty;
  dpa_item_t   push_item, head_item;
  logic        back_en;

  logic        v_r    [ASYM_LAT];
  logic [15:0] idx_r  [ASYM_LAT];
  logic        zero_r [ASYM_LAT];
  logic [15:0] ph_r   [PHASE_DLY];
  logic [15:0] cordic_phase;
  logic [16:0] asym;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_x_r   <= '0;
      sample_y_r   <= '0;
      sample_z_r   <= '0;
      field_axis_r <= AXIS_X;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_SAMPLE_X:   sample_x_r   <= cfg_wdata;
        REG_SAMPLE_Y:   sample_y_r   <= cfg_wdata;
        REG_SAMPLE_Z:   sample_z_r   <= cfg_wdata;
        REG_FIELD_AXIS: field_axis_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  dpa_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_det_index (in_det_index),
    .in_det_x     (in_det_x),
    .in_det_y     (in_det_y),
    .in_det_z     (in_det_z),
    .sample_x     (sample_x_r),
    .sample_y     (sample_y_r),
    .sample_z     (sample_z_r),
    .field_axis   (field_axis_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  dpa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back pipeline advances unless the finished item is held
  assign back_en = !(v_r[ASYM_LAT-1] && out_stall);
  assign q_pop   = back_en && !q_empty;

  dpa_cordic u_cordic (
    .clk     (clk),
    .en      (back_en),
    .num_neg (head_item.num_neg),
    .mag_n   (head_item.mag_n),
    .den_neg (head_item.den_neg),
    .mag_d   (head_item.mag_d),
    .phase   (cordic_phase)
  );

  dpa_asym u_asym (
    .clk   (clk),
    .en    (back_en),
    .mag_n (head_item.mag_n),
    .mag_d (head_item.mag_d),
    .mag_o (head_item.mag_o),
    .asym  (asym)
  );

  // valid bits along the back pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < ASYM_LAT; s++) v_r[s] <= 1'b0;
    end else if (back_en) begin
      v_r[0] <= !q_empty;
      for (int s = 1; s < ASYM_LAT; s++) v_r[s] <= v_r[s-1];
    end
  end

  // index, zero flag and phase ride alongside
  always_ff @(posedge clk) begin
    if (back_en) begin
      idx_r[0]  <= head_item.index;
      zero_r[0] <= head_item.zero;
      for (int s = 1; s < ASYM_LAT; s++) begin
        idx_r[s]  <= idx_r[s-1];
        zero_r[s] <= zero_r[s-1];
      end
      ph_r[0] <= cordic_phase;
      for (int s = 1; s < PHASE_DLY; s++) ph_r[s] <= ph_r[s-1];
    end
  end

  assign out_valid       = v_r[ASYM_LAT-1];
  assign out_index       = idx_r[ASYM_LAT-1];
  assign out_zero_radius = zero_r[ASYM_LAT-1];
  assign out_phase       = ph_r[PHASE_DLY-1];
  assign out_asymmetry   = zero_r[ASYM_LAT-1] ? 17'd0 : asym;

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> !q_pop) else $error("queue read while empty");

  a_asym_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_asymmetry <= 17'd65536) else $error("asymmetry above one");

  a_zero_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_radius |-> out_phase == 16'h8000)
    else $error("zero radius without half turn phase");

endmodule

// ----- rtl/core/dpa_front.sv -----
`timescale 1ns / 1ps
module dpa_front
  import dpa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [15:0]      in_det_index,
  input  logic [31:0]      in_det_x,
  input  logic [31:0]      in_det_y,
  input  logic [31:0]      in_det_z,
  input  logic [31:0]      sample_x,
  input  logic [31:0]      sample_y,
  input  logic [31:0]      sample_z,
  input  logic [1:0]       field_axis,
  input  logic             q_full,
  output logic             q_push,
  output dpa_item_t        q_item
);

  logic        en;
  logic [2:0]  v_r;

  // stage 1: difference and magnitude
  logic [32:0] dx, dy, dz, ax, ay, az;
  logic [31:0] mn_nxt, md_nxt, mo_nxt;
  logic        nn_nxt, dn_nxt;

  logic [15:0] idx1_r, idx2_r;
  logic        nn1_r, dn1_r, nn2_r, dn2_r;
  logic [31:0] mn1_r, md1_r, mo1_r, mn2_r, md2_r, mo2_r;
  logic [4:0]  lead_nxt, lead_r;
  logic        zero_nxt, zero_r;
  logic [31:0] orm;
  logic [4:0]  rsh, lsh;
  logic [31:0] sn, sd, so;
  dpa_item_t   item_r;

  assign en       = !(v_r[2] && q_full);
  assign in_stall = !en;
  assign q_push   = v_r[2] && !q_full;
  assign q_item   = item_r;

  assign dx = {in_det_x[31], in_det_x} - {sample_x[31], sample_x};
  assign dy = {in_det_y[31], in_det_y} - {sample_y[31], sample_y};
  assign dz = {in_det_z[31], in_det_z} - {sample_z[31], sample_z};
  assign ax = dx[32] ? (~dx + 33'd1) : dx;
  assign ay = dy[32] ? (~dy + 33'd1) : dy;
  assign az = dz[32] ? (~dz + 33'd1) : dz;

  // pick numerator, denominator and axial component
  always_comb begin
    unique case (field_axis)
      AXIS_X: begin
        mn_nxt = az[31:0]; nn_nxt = dz[32];
        md_nxt = ay[31:0]; dn_nxt = dy[32];
        mo_nxt = ax[31:0];
      end
      AXIS_Y: begin
        mn_nxt = ax[31:0]; nn_nxt = dx[32];
        md_nxt = az[31:0]; dn_nxt = dz[32];
        mo_nxt = ay[31:0];
      end
      default: begin
        mn_nxt = ay[31:0]; nn_nxt = dy[32];
        md_nxt = ax[31:0]; dn_nxt = dx[32];
        mo_nxt = az[31:0];
      end
    endcase
  end

  // stage 2: leading one of the largest magnitude
  assign orm = mn1_r | md1_r | mo1_r;
  always_comb begin
    lead_nxt = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (orm[i]) lead_nxt = 5'(i);
    end
    zero_nxt = (orm == 32'd0);
  end

  // stage 3: common scale into [2^29, 2^30)
  assign rsh = (lead_r > 5'd29) ? (lead_r - 5'd29) : 5'd0;
  assign lsh = (lead_r < 5'd29) ? (5'd29 - lead_r) : 5'd0;
  assign sn  = (mn2_r >> rsh) << lsh;
  assign sd  = (md2_r >> rsh) << lsh;
  assign so  = (mo2_r >> rsh) << lsh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 3'b000;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1_r <= in_det_index;
      nn1_r  <= nn_nxt;
      dn1_r  <= dn_nxt;
      mn1_r  <= mn_nxt;
      md1_r  <= md_nxt;
      mo1_r  <= mo_nxt;
      idx2_r <= idx1_r;
      nn2_r  <= nn1_r;
      dn2_r  <= dn1_r;
      mn2_r  <= mn1_r;
      md2_r  <= md1_r;
      mo2_r  <= mo1_r;
      lead_r <= lead_nxt;
      zero_r <= zero_nxt;
      item_r.index   <= idx2_r;
      item_r.num_neg <= nn2_r;
      item_r.den_neg <= dn2_r;
      item_r.mag_n   <= sn[MAG_W-1:0];
      item_r.mag_d   <= sd[MAG_W-1:0];
      item_r.mag_o   <= so[MAG_W-1:0];
      item_r.zero    <= zero_r;
    end
  end

endmodule

// ----- rtl/core/dpa_queue.sv -----
`timescale 1ns / 1ps
module dpa_queue
  import dpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  dpa_item_t push_item,
  input  logic      pop,
  output dpa_item_t head_item,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  dpa_item_t        mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;

  assign full      = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign empty     = (cnt_r == '0);
  assign head_item = mem_r[rd_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + PTR_W'(1);
      if (pop)  rd_r <= rd_r + PTR_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (!push && pop) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_item;
  end

endmodule

// ----- rtl/core/dpa_cordic.sv -----
`timescale 1ns / 1ps
module dpa_cordic
  import dpa_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic             num_neg,
  input  logic [MAG_W-1:0] mag_n,
  input  logic             den_neg,
  input  logic [MAG_W-1:0] mag_d,
  output logic [15:0]      phase
);

  localparam int          SH_DN = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
  localparam int          SH_UP = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
  localparam logic [31:0] ROUND = 32'd1 << (31 - ANGLE_BITS);

  logic signed [33:0] x_r [CORDIC_STEPS+1];
  logic signed [33:0] y_r [CORDIC_STEPS+1];
  logic [31:0]        z_r [CORDIC_STEPS+1];
  logic               zp_r [CORDIC_STEPS+1];

  logic signed [33:0] xin, yin;
  logic [31:0]        zf, sum, ph32, ph16;
  logic [15:0]        phase_r;

  assign xin = den_neg ? -$signed({4'd0, mag_d}) : $signed({4'd0, mag_d});
  assign yin = num_neg ? -$signed({4'd0, mag_n}) : $signed({4'd0, mag_n});

  // pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      zp_r[0] <= (mag_n == '0) && (mag_d == '0);
      if (xin < 0) begin
        x_r[0] <= -xin;
        y_r[0] <= -yin;
        z_r[0] <= HALF_TURN;
      end else begin
        x_r[0] <= xin;
        y_r[0] <= yin;
        z_r[0] <= 32'd0;
      end
    end
  end

  // one vectoring step per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        zp_r[i+1] <= zp_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_turn(i);
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_turn(i);
        end
      end
    end
  end

  // shift by half a turn, round and rescale
  assign zf   = zp_r[CORDIC_STEPS] ? 32'd0 : z_r[CORDIC_STEPS];
  assign sum  = zf + HALF_TURN + ROUND;
  assign ph32 = sum >> (32 - ANGLE_BITS);
  assign ph16 = (ANGLE_BITS >= 16) ? (ph32 >> SH_DN) : (ph32 << SH_UP);

  always_ff @(posedge clk) begin
    if (en) phase_r <= ph16[15:0];
  end

  assign phase = phase_r;

endmodule

// ----- rtl/core/dpa_asym.sv -----
`timescale 1ns / 1ps
module dpa_asym
  import dpa_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [MAG_W-1:0] mag_n,
  input  logic [MAG_W-1:0] mag_d,
  input  logic [MAG_W-1:0] mag_o,
  output logic [16:0]      asym
);

  localparam int SQ_W  = 2 * MAG_W;
  localparam int REM_W = SQ_W + 3;

  logic [SQ_W-1:0]  sqn_r, sqd_r, sqo_r, prod_n, prod_d, prod_o;
  logic [REM_W-1:0] p_r, r_r;
  logic [REM_W-1:0] rem_r [DIV_STEPS];
  logic [REM_W-1:0] div_r [DIV_STEPS];
  logic [32:0]      q_r   [DIV_STEPS];
  logic [35:0]      t_r   [SQRT_STEPS];
  logic [35:0]      res_r [SQRT_STEPS];
  logic [35:0]      t_in  [SQRT_STEPS];
  logic [35:0]      res_in [SQRT_STEPS];

  // squares and their sums
  assign prod_n = mag_n * mag_n;
  assign prod_d = mag_d * mag_d;
  assign prod_o = mag_o * mag_o;

  always_ff @(posedge clk) begin
    if (en) begin
      sqn_r <= prod_n;
      sqd_r <= prod_d;
      sqo_r <= prod_o;
      p_r   <= REM_W'(sqn_r) + REM_W'(sqd_r);
      r_r   <= REM_W'(sqn_r) + REM_W'(sqd_r) + REM_W'(sqo_r);
    end
  end

  // restoring division, first quotient bit
  always_ff @(posedge clk) begin
    if (en) begin
      div_r[0] <= r_r;
      if (p_r >= r_r) begin
        rem_r[0] <= p_r - r_r;
        q_r[0]   <= 33'd1;
      end else begin
        rem_r[0] <= p_r;
        q_r[0]   <= 33'd0;
      end
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k < DIV_STEPS; k++) begin : g_div
    logic [REM_W-1:0] rem2;
    assign rem2 = {rem_r[k-1][REM_W-2:0], 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        div_r[k] <= div_r[k-1];
        if (rem2 >= div_r[k-1]) begin
          rem_r[k] <= rem2 - div_r[k-1];
          q_r[k]   <= {q_r[k-1][31:0], 1'b1};
        end else begin
          rem_r[k] <= rem2;
          q_r[k]   <= {q_r[k-1][31:0], 1'b0};
        end
      end
    end
  end

  // integer square root, one result bit per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [35:0] BITV = 36'd1 << (2 * (SQRT_STEPS - 1 - j));
    if (j == 0) begin : g_first
      assign t_in[j]   = {3'd0, q_r[DIV_STEPS-1]};
      assign res_in[j] = 36'd0;
    end else begin : g_next
      assign t_in[j]   = t_r[j-1];
      assign res_in[j] = res_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (t_in[j] >= res_in[j] + BITV) begin
          t_r[j]   <= t_in[j] - (res_in[j] + BITV);
          res_r[j] <= (res_in[j] >> 1) + BITV;
        end else begin
          t_r[j]   <= t_in[j];
          res_r[j] <= res_in[j] >> 1;
        end
      end
    end
  end

  assign asym = res_r[SQRT_STEPS-1][16:0];

endmodule

// ----- tb/detector_phase_asymmetry_test.sv -----
`timescale 1ns / 1ps
module detector_phase_asymmetry_test;
  import dpa_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 80;
  localparam int NUM_PHASES   = 6;
  localparam int ITEMS_PER_PH = 125;

  // atan(2^-i) in 2^-32 turn units
  localparam logic [31:0] ARCTAN_STEP [30] = '{
    32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335086,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
    32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162,
    32'd81, 32'd40, 32'd20, 32'd10, 32'd5, 32'd2, 32'd1};

  typedef struct {
    logic [15:0] index;
    logic [15:0] phase;
    logic [16:0] asym;
    logic        zero;
  } polar_t;

  typedef struct {
    logic [15:0] idx;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    bit          typed;
    logic [15:0] phase;
    logic [16:0] asym;
    logic        zero;
  } det_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_det_index = '0;
  logic [31:0] in_det_x = '0;
  logic [31:0] in_det_y = '0;
  logic [31:0] in_det_z = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_index;
  logic [15:0] out_phase;
  logic [16:0] out_asymmetry;
  logic        out_zero_radius;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  // shadow configuration
  logic [31:0] samp_x = '0;
  logic [31:0] samp_y = '0;
  logic [31:0] samp_z = '0;
  logic [1:0]  axis_sel = AXIS_X;

  polar_t pending_q[$];
  int     err_count = 0;
  int     cycle_count = 0;

  // directed items, reset configuration (sample at origin, field along x)
  det_row_t dir_rows [15] = '{
    '{16'h0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1, 16'd32768, 17'd0, 1'b1},
    '{16'hFFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1, 16'd32768, 17'd0, 1'b0},
    '{16'h0001, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1, 16'd32768, 17'd0, 1'b0},
    '{16'h0002, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 0, 16'd0, 17'd0, 1'b0},
    '{16'h0003, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 0, 16'd0, 17'd0, 1'b0},
    '{16'h0004, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 0, 16'd0, 17'd0, 1'b0},
    '{16'h0005, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 0, 16'd0, 17'd0, 1'b0},
    '{16'h0006, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 16'd0, 17'd0, 1'b0},
    '{16'h0007, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 16'd0, 17'd0, 1'b0},
    '{16'h0008, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 1, 16'd32768, 17'd0, 1'b0},
    '{16'h0009, 32'h0000_0000, 32'h0000_0001, 32'h0000_0001, 0, 16'd0, 17'd0, 1'b0},
    '{16'h000A, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 16'd0, 17'd0, 1'b0},
    '{16'h000B, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 0, 16'd0, 17'd0, 1'b0},
    '{16'h000C, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 0, 16'd0, 17'd0, 1'b0},
    '{16'h000D, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 0, 16'd0, 17'd0, 1'b0}
  };

  detector_phase_asymmetry dut (.*);

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // phase and asymmetry of one detector under the current configuration
  function automatic polar_t polar_of(logic [15:0] idx, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z);
    longint            dv [3];
    longint unsigned   mag [3];
    bit                neg [3];
    longint unsigned   m, p, r, q, rem, bitv, root;
    int                rs, ls, ni, di, oi;
    longint            num, den, cx, cy, xs, ys;
    logic [31:0]       ang, ph;
    polar_t            o;
    dv[0] = longint'(signed'(x)) - longint'(signed'(samp_x));
    dv[1] = longint'(signed'(y)) - longint'(signed'(samp_y));
    dv[2] = longint'(signed'(z)) - longint'(signed'(samp_z));
    m = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = dv[i] < 0;
      mag[i] = neg[i] ? longint'(-dv[i]) : longint'(dv[i]);
      if (mag[i] > m) m = mag[i];
    end
    case (axis_sel)
      AXIS_X: begin ni = 2; di = 1; oi = 0; end
      AXIS_Y: begin ni = 0; di = 2; oi = 1; end
      default: begin ni = 1; di = 0; oi = 2; end
    endcase
    o.index = idx;
    o.asym = '0;
    o.zero = 1'b0;
    num = 0;
    den = 0;
    if (m == 0) begin
      o.zero = 1'b1;
    end else begin
      rs = 0;
      ls = 0;
      while (m >= (64'd1 << 30)) begin m = m >> 1; rs++; end
      while (m < (64'd1 << 29)) begin m = m << 1; ls++; end
      for (int i = 0; i < 3; i++) mag[i] = (mag[i] >> rs) << ls;
      num = neg[ni] ? -longint'(mag[ni]) : longint'(mag[ni]);
      den = neg[di] ? -longint'(mag[di]) : longint'(mag[di]);
      // restoring division to 32 fraction bits
      p = mag[ni] * mag[ni] + mag[di] * mag[di];
      r = p + mag[oi] * mag[oi];
      q = 0;
      rem = p;
      if (rem >= r) begin rem -= r; q = 1; end
      for (int i = 0; i < 32; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= r) begin rem -= r; q |= 1; end
      end
      // integer square root
      root = 0;
      bitv = 64'd1 << 34;
      while (bitv > q) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (q >= root + bitv) begin
          q -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      o.asym = root[16:0];
    end
    // vectoring cordic on (den, num)
    ang = '0;
    if (num != 0 || den != 0) begin
      cx = den;
      cy = num;
      if (cx < 0) begin
        cx = -cx;
        cy = -cy;
        ang = HALF_TURN;
      end
      for (int i = 0; i < 30; i++) begin
        xs = cx >>> i;
        ys = cy >>> i;
        if (cy >= 0) begin
          cx = cx + ys;
          cy = cy - xs;
          ang = ang + ARCTAN_STEP[i];
        end else begin
          cx = cx - ys;
          cy = cy + xs;
          ang = ang - ARCTAN_STEP[i];
        end
      end
    end
    ph = ang + HALF_TURN + (32'd1 << (31 - ANGLE_BITS));
    ph = ph >> (32 - ANGLE_BITS);
    if (ANGLE_BITS >= 16) o.phase = 16'(ph >> (ANGLE_BITS - 16));
    else o.phase = 16'(ph << (16 - ANGLE_BITS));
    return o;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_SAMPLE_X: samp_x = val;
      REG_SAMPLE_Y: samp_y = val;
      REG_SAMPLE_Z: samp_z = val;
      default: axis_sel = val[1:0];
    endcase
  endtask

  // wait for the pipeline to empty before touching registers
  task automatic wait_idle();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic sender_gap();
    int sel, n;
    sel = $urandom_range(0, 99);
    if (sel < 50) n = 0;
    else if (sel < 90) n = $urandom_range(1, 3);
    else if (sel < 98) n = $urandom_range(4, 10);
    else n = $urandom_range(20, 60);
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  // drive one item and hold it until taken
  task automatic send_det(logic [15:0] idx, logic [31:0] x, logic [31:0] y,
                          logic [31:0] z, bit typed, polar_t known);
    @(negedge clk);
    in_valid = 1'b1;
    in_det_index = idx;
    in_det_x = x;
    in_det_y = y;
    in_det_z = z;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(typed ? known : polar_of(idx, x, y, z));
    sender_gap();
  endtask

  function automatic logic [31:0] pick_coord(logic [31:0] samp);
    int sel;
    sel = $urandom_range(0, 9);
    case (sel) inside
      0: return samp;
      [1:3]: return samp + 32'($signed($urandom_range(0, 511)) - 256);
      4: return 32'h7FFF_FFFF;
      5: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(int n);
    logic [31:0] x, y, z;
    polar_t      none;
    int          sel;
    none = '{default: '0};
    repeat (n) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        // exactly on the sample
        x = samp_x; y = samp_y; z = samp_z;
      end else if (sel < 4) begin
        // close to the sample, exercises the upscaling
        x = samp_x + 32'($signed($urandom_range(0, 4095)) - 2048);
        y = samp_y + 32'($signed($urandom_range(0, 4095)) - 2048);
        z = samp_z + 32'($signed($urandom_range(0, 4095)) - 2048);
      end else if (sel < 7) begin
        x = pick_coord(samp_x); y = pick_coord(samp_y); z = pick_coord(samp_z);
      end else begin
        x = $urandom; y = $urandom; z = $urandom;
      end
      send_det(16'($urandom), x, y, z, 1'b0, none);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    polar_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("unexpected item index %0d", out_index);
        err_count++;
      end else begin
        exp_r = pending_q.pop_front();
        if (out_index !== exp_r.index) begin
          $error("index exp %0d got %0d", exp_r.index, out_index);
          err_count++;
        end
        if (out_phase !== exp_r.phase) begin
          $error("phase exp %0d got %0d", exp_r.phase, out_phase);
          err_count++;
        end
        if (out_asymmetry !== exp_r.asym) begin
          $error("asymmetry exp %0d got %0d", exp_r.asym, out_asymmetry);
          err_count++;
        end
        if (out_zero_radius !== exp_r.zero) begin
          $error("zero_radius exp %0d got %0d", exp_r.zero, out_zero_radius);
          err_count++;
        end
      end
    end
  end

  // receiver back-pressure: short runs mostly, a few long ones
  initial begin
    int run;
    forever begin
      @(negedge clk);
      out_stall = 1'b0;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 6);
      repeat (run) @(negedge clk);
      if ($urandom_range(0, 3) != 0) begin
        out_stall = 1'b1;
        run = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
        repeat (run) @(negedge clk);
      end
    end
  end

  // main sequence
  initial begin
    polar_t known;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // directed items at reset configuration
    foreach (dir_rows[i]) begin
      known = '{dir_rows[i].idx, dir_rows[i].phase, dir_rows[i].asym, dir_rows[i].zero};
      send_det(dir_rows[i].idx, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
               dir_rows[i].typed, known);
    end
    send_random(ITEMS_PER_PH - 15);
    for (int ph = 1; ph < NUM_PHASES; ph++) begin
      @(negedge clk);
      in_valid = 1'b0;
      wait_idle();
      case (ph)
        1: begin
          write_reg(REG_SAMPLE_X, 32'h7FFF_FFFF);
          write_reg(REG_SAMPLE_Y, 32'h7FFF_FFFF);
          write_reg(REG_SAMPLE_Z, 32'h7FFF_FFFF);
          write_reg(REG_FIELD_AXIS, AXIS_Y);
        end
        2: begin
          write_reg(REG_SAMPLE_X, 32'h8000_0000);
          write_reg(REG_SAMPLE_Y, 32'h8000_0000);
          write_reg(REG_SAMPLE_Z, 32'h8000_0000);
          write_reg(REG_FIELD_AXIS, AXIS_Z);
        end
        3: begin
          write_reg(REG_SAMPLE_X, $urandom);
          write_reg(REG_SAMPLE_Y, $urandom);
          write_reg(REG_SAMPLE_Z, $urandom);
          write_reg(REG_FIELD_AXIS, 2'd3);
        end
        default: begin
          write_reg(REG_SAMPLE_X, 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)));
          write_reg(REG_SAMPLE_Y, $urandom);
          write_reg(REG_SAMPLE_Z, 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)));
          write_reg(REG_FIELD_AXIS, 2'($urandom_range(0, 3)));
        end
      endcase
      // corner detectors under the new configuration
      send_det(16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, known);
      send_det(16'h0000, samp_x, samp_y, samp_z, 1'b0, known);
      send_random(ITEMS_PER_PH - 2);
    end
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/dpa_pkg.sv
rtl/core/dpa_front.sv
rtl/core/dpa_queue.sv
rtl/core/dpa_cordic.sv
rtl/core/dpa_asym.sv
rtl/core/detector_phase_asymmetry.sv
tb/detector_phase_asymmetry_test.sv
